### src/r4p_pkg.sv
// r4p_pkg: shared types and constants for the 4D rotate / 3D projection block.
// No dependencies; used by every file under src.
package r4p_pkg;

  localparam int NumPlanes = 6;
  localparam int NumRegs   = 8;
  localparam int RegIdxW   = 3;

  localparam logic [RegIdxW-1:0] RegEye  = 3'd6;
  localparam logic [RegIdxW-1:0] RegMode = 3'd7;

  localparam logic [63:0] RotReset = 64'h4000_0000_0000_0000;
  localparam logic signed [31:0] EyeReset = 32'sd327680;

  // Divider: 48-bit dividend magnitude, 33-bit divisor magnitude.
  localparam int DivNumW  = 48;
  localparam int DivDenW  = 33;
  localparam int DivSteps = 48;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vec4_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               fault;
  } result_t;

  // Work item handed from the rotation front to the projection back.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [32:0] den;
    logic               ortho;
  } proj_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### src/r4p_if.sv
// r4p_if: valid/ready channel interfaces for vertices, results and config writes.
// Depends on r4p_pkg.
interface r4p_vec_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;
  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface r4p_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic              divide_fault;
  modport source (output valid, out_x, out_y, out_z, divide_fault, input ready);
  modport sink   (input valid, out_x, out_y, out_z, divide_fault, output ready);
endinterface

interface r4p_cfg_if;
  logic        valid;
  logic        ready;
  logic [r4p_pkg::RegIdxW-1:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/r4p_rotate.sv
// r4p_rotate: six-stage pipeline of plane rotations, one plane per stage.
// Each stage splits into a multiply register and a round/saturate register.
// Depends on r4p_pkg.
module r4p_rotate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  r4p_pkg::vec4_t            vin,
  input  logic [63:0]               rot [r4p_pkg::NumPlanes],
  output logic                      out_valid,
  output r4p_pkg::vec4_t            vout
);

  localparam int NS = 2 * r4p_pkg::NumPlanes;

  // Plane order XY XZ XW YZ YW ZW as coordinate index pairs.
  localparam logic [1:0] PA [r4p_pkg::NumPlanes] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PB [r4p_pkg::NumPlanes] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  logic [NS:0] vld;
  logic signed [31:0] crd [NS+1][4];
  logic signed [63:0] prod [r4p_pkg::NumPlanes][4];

  assign vld[0] = in_valid;
  assign crd[0][0] = vin.x;
  assign crd[0][1] = vin.y;
  assign crd[0][2] = vin.z;
  assign crd[0][3] = vin.w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[NS:1] <= '0;
    end else if (advance) begin
      vld[NS:1] <= vld[NS-1:0];
    end
  end

  for (genvar p = 0; p < r4p_pkg::NumPlanes; p++) begin : g_plane
    logic signed [31:0] c, s;
    logic signed [31:0] ra, rb;
    logic signed [65:0] suma, sumb;
    assign c = rot[p][63:32];
    assign s = rot[p][31:0];

    // multiply stage: ca, sb, -sa (as s*a, negated later), cb
    always_ff @(posedge clk) begin
      if (advance) begin
        prod[p][0] <= c * crd[2*p][PA[p]];
        prod[p][1] <= s * crd[2*p][PB[p]];
        prod[p][2] <= s * crd[2*p][PA[p]];
        prod[p][3] <= c * crd[2*p][PB[p]];
        for (int k = 0; k < 4; k++) begin
          crd[2*p+1][k] <= crd[2*p][k];
        end
      end
    end

    // exact sum plus half, floor by 2^30 equals the rounded result
    assign suma = 66'(prod[p][0]) + 66'(prod[p][1]) + 66'sd536870912;
    assign sumb = 66'(prod[p][3]) - 66'(prod[p][2]) + 66'sd536870912;
    assign ra = r4p_pkg::sat32(suma >>> 30);
    assign rb = r4p_pkg::sat32(sumb >>> 30);

    always_ff @(posedge clk) begin
      if (advance) begin
        for (int k = 0; k < 4; k++) begin
          if (k == int'(PA[p])) begin
            crd[2*p+2][k] <= ra;
          end else if (k == int'(PB[p])) begin
            crd[2*p+2][k] <= rb;
          end else begin
            crd[2*p+2][k] <= crd[2*p+1][k];
          end
        end
      end
    end
  end

  assign out_valid = vld[NS];
  assign vout.x = crd[NS][0];
  assign vout.y = crd[NS][1];
  assign vout.z = crd[NS][2];
  assign vout.w = crd[NS][3];

endmodule

### src/r4p_queue.sv
// r4p_queue: small FIFO of projection requests between front and back.
// Depends on r4p_pkg.
module r4p_queue #(
  parameter int Depth = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  r4p_pkg::proj_req_t   wdata,
  input  logic                 pop,
  output r4p_pkg::proj_req_t   rdata,
  output logic                 empty,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = $clog2(Depth);

  r4p_pkg::proj_req_t mem [Depth];
  logic [AW-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata = mem[rptr];
  assign empty = (count == '0);

endmodule

### src/r4p_divide.sv
// r4p_divide: pipelined restoring divider, one quotient bit per stage, plus
// output saturation and fault handling.
// Depends on r4p_pkg.
module r4p_divide (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  r4p_pkg::proj_req_t  req,
  output logic                out_valid,
  output r4p_pkg::result_t    res
);

  localparam int NW = r4p_pkg::DivNumW;
  localparam int DW = r4p_pkg::DivDenW;
  localparam int N  = r4p_pkg::DivSteps;

  typedef struct packed {
    logic [2:0][NW-1:0] q;     // quotient bits shift in here, dividend out
    logic [2:0][DW:0]   rem;
    logic [2:0]         qneg;
    logic [DW-1:0]      dmag;
    logic signed [2:0][31:0] pass;
    logic               ortho;
    logic               zero;
  } dstage_t;

  dstage_t st [N+1];
  logic [N:0] vld;

  function automatic logic [NW-1:0] mag_num(input logic signed [31:0] v);
    logic signed [NW:0] t;
    t = (NW+1)'(v) <<< 16;
    return t[NW] ? NW'(-t) : NW'(t);
  endfunction

  always_comb begin
    logic signed [31:0] cv [3];
    cv[0] = req.x;
    cv[1] = req.y;
    cv[2] = req.z;
    st[0] = '0;
    for (int k = 0; k < 3; k++) begin
      st[0].q[k]    = mag_num(cv[k]);
      st[0].qneg[k] = cv[k][31] ^ req.den[32];
      st[0].pass[k] = cv[k];
    end
    st[0].dmag  = req.den[32] ? DW'(-req.den) : DW'(req.den);
    st[0].ortho = req.ortho;
    st[0].zero  = (req.den == '0);
  end
  assign vld[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_step
    dstage_t nx;
    always_comb begin
      logic [DW:0] tr;
      nx = st[i];
      for (int k = 0; k < 3; k++) begin
        tr = {st[i].rem[k][DW-1:0], st[i].q[k][NW-1]};
        if (tr >= {1'b0, st[i].dmag}) begin
          nx.rem[k] = tr - {1'b0, st[i].dmag};
          nx.q[k]   = {st[i].q[k][NW-2:0], 1'b1};
        end else begin
          nx.rem[k] = tr;
          nx.q[k]   = {st[i].q[k][NW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        st[i+1] <= nx;
      end
    end
  end

  always_comb begin
    logic signed [65:0] sq;
    logic signed [31:0] o [3];
    for (int k = 0; k < 3; k++) begin
      sq = st[N].qneg[k] ? -66'($unsigned(st[N].q[k])) : 66'($unsigned(st[N].q[k]));
      if (st[N].ortho) begin
        o[k] = st[N].pass[k];
      end else if (st[N].zero) begin
        o[k] = '0;
      end else begin
        o[k] = r4p_pkg::sat32(sq);
      end
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    res.fault = !st[N].ortho && st[N].zero;
  end
  assign out_valid = vld[N];

endmodule

### src/rotate4d_project3d.sv
// Rotates one signed Q16.16 4D vertex through the XY, XZ, XW, YZ, YW and ZW
// planes and projects it stereographically by (d - w) or orthogonally.
// Rate: one vertex per clock sustained while the output is ready. Each
// request holds one unit of queue credit while it is in the rotation
// pipeline and in the queue. Full rate needs QueueDepth >= 14.
// From acceptance to a valid result, a vertex passes in order through:
// - the rotation pipeline (one multiply and one round stage per plane)
// - the request queue
// - the radix-2 quotient pipeline, one quotient bit per stage
// - the output buffer
// A stalled output freezes the divider, and the queue absorbs the rotation
// front until credit runs out. Config writes are taken at any time and must
// only be issued while the block is idle.
// Depends on r4p_pkg and the r4p interfaces.
module rotate4d_project3d #(
  parameter int QueueDepth = 16
) (
  input  logic  clk,
  input  logic  rst,
  r4p_vec_if.sink   vin,
  r4p_res_if.source vout,
  r4p_cfg_if.sink   cfg
);

  localparam int RotLat = 2 * r4p_pkg::NumPlanes;
  localparam int CW     = $clog2(QueueDepth + 1);
  localparam int FW     = CW + 1;

  logic [63:0]        rot [r4p_pkg::NumPlanes];
  logic signed [31:0] eye;
  logic               mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < r4p_pkg::NumPlanes; p++) begin
        rot[p] <= r4p_pkg::RotReset;
      end
      eye  <= r4p_pkg::EyeReset;
      mode <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == r4p_pkg::RegEye) begin
        eye <= cfg.data[31:0];
      end else if (cfg.index == r4p_pkg::RegMode) begin
        mode <= cfg.data[0];
      end else begin
        rot[cfg.index] <= cfg.data;
      end
    end
  end

  // front: rotation pipeline never stalls; intake stops only when queue credit runs out
  r4p_pkg::vec4_t rin, rout;
  logic           rvalid;
  logic [CW-1:0]  qcount;
  logic [CW-1:0]  inflight;
  logic           f_adv, take;

  assign rin.x = vin.in_x;
  assign rin.y = vin.in_y;
  assign rin.z = vin.in_z;
  assign rin.w = vin.in_w;

  // credit: items in rotation pipe plus queue must not exceed queue depth
  assign vin.ready = (FW'(qcount) + FW'(inflight)) < FW'(QueueDepth);
  assign take  = vin.valid && vin.ready;
  assign f_adv = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + (take ? CW'(1) : CW'(0)) - (rvalid ? CW'(1) : CW'(0));
    end
  end

  r4p_rotate u_rot (
    .clk, .rst, .advance(f_adv), .in_valid(take), .vin(rin), .rot,
    .out_valid(rvalid), .vout(rout)
  );

  r4p_pkg::proj_req_t qin, qout;
  logic qempty, qpop;
  assign qin.x     = rout.x;
  assign qin.y     = rout.y;
  assign qin.z     = rout.z;
  assign qin.den   = 33'(eye) - 33'(rout.w);
  assign qin.ortho = mode;

  r4p_queue #(.Depth(QueueDepth)) u_q (
    .clk, .rst, .push(rvalid), .wdata(qin), .pop(qpop), .rdata(qout),
    .empty(qempty), .count(qcount)
  );

  // back: divider pipeline advances whenever its output slot can take data
  r4p_pkg::result_t dres, obuf;
  logic dvalid, ovalid, b_adv;

  assign b_adv = !dvalid || !ovalid || vout.ready;
  assign qpop  = b_adv && !qempty;

  r4p_divide u_div (
    .clk, .rst, .advance(b_adv), .in_valid(qpop), .req(qout),
    .out_valid(dvalid), .res(dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (!ovalid || vout.ready) begin
      ovalid <= dvalid && b_adv;
    end
  end
  always_ff @(posedge clk) begin
    if ((!ovalid || vout.ready) && dvalid) begin
      obuf <= dres;
    end
  end

  assign vout.valid        = ovalid;
  assign vout.out_x        = obuf.x;
  assign vout.out_y        = obuf.y;
  assign vout.out_z        = obuf.z;
  assign vout.divide_fault = obuf.fault;

  a_credit : assert property (@(posedge clk) disable iff (rst)
    (FW'(qcount) + FW'(inflight)) <= FW'(QueueDepth))
    else $error("queue credit exceeded");
  a_noover : assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (qcount < CW'(QueueDepth)))
    else $error("push into full queue");
  a_lat : assert property (@(posedge clk) disable iff (rst)
    take |-> ##(RotLat) rvalid)
    else $error("rotation result missing");

endmodule
